// ===== hw/rtl/svt_pkg.sv =====
// Shared constants, types and field widths of the sector validity tracker.
package svt_pkg;

    // Geometry of the tracked device
    localparam int NUM_PU_GROUPS = 4;
    localparam int NUM_PU_UNITS  = 4;
    localparam int NUM_CHUNKS    = 32;
    localparam int NUM_SECTORS   = 256;

    localparam int CHUNK_TOTAL  = NUM_PU_GROUPS * NUM_PU_UNITS * NUM_CHUNKS;
    localparam int SECTOR_TOTAL = CHUNK_TOTAL * NUM_SECTORS;

    // Index and counter widths
    localparam int CI_W  = (CHUNK_TOTAL > 1) ? $clog2(CHUNK_TOTAL) : 1;
    localparam int SI_W  = (SECTOR_TOTAL > 1) ? $clog2(SECTOR_TOTAL) : 1;
    localparam int CNT_W = $clog2(NUM_SECTORS + 1);

    // Port field widths
    localparam int GRP_W       = 2;
    localparam int UNIT_W      = 2;
    localparam int CHUNK_W     = 5;
    localparam int SECTOR_W    = 8;
    localparam int STATE_W     = 2;
    localparam int COUNT_OUT_W = 9;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Commands
    localparam logic CMD_MARK_VALID   = 1'b0;
    localparam logic CMD_MARK_INVALID = 1'b1;

    // Sector states
    localparam logic [STATE_W-1:0] ST_UNUSED   = 2'd0;
    localparam logic [STATE_W-1:0] ST_VALID    = 2'd1;
    localparam logic [STATE_W-1:0] ST_INVALID  = 2'd2;
    localparam logic [STATE_W-1:0] ST_RESERVED = 2'd3;

    // One classified operation as it travels through the queue
    typedef struct packed {
        logic            cmd;
        logic            in_range;
        logic [CI_W-1:0] ci;
        logic [SI_W-1:0] si;
        logic            last;
    } svt_op_t;

    // Status from the back end to the front end
    typedef struct packed {
        logic clearing;
    } svt_back_stat_t;

endpackage

// ===== hw/rtl/sector_validity_tracker_unit.sv =====
// Sector validity tracker top level: front end, operation queue and back end.
//
// Tracks the state (unused, valid, invalid) of every flash sector and the
// per-chunk counts of valid and invalid sectors. Each input beat names a
// sector by group, unit, chunk and sector and marks it valid or invalid;
// each beat yields exactly one result beat with the prior state, the
// chunk's counts after the update, a changed flag and the batch marker.
// Addresses outside the configured geometry leave the store alone and
// report zeros. After reset the stores are swept to zero, one sector entry
// per cycle: item_ready stays low until all 131072 sector entries are clear.
// After that the back end reads the sector state and chunk counts of an item
// as it pops it in S_IDLE, then updates and writes them back in S_EXEC as the
// result is loaded, waiting there while the result register is still full;
// it pops no new item before that. A two-entry queue lets input beats be
// taken while the back end works, and a result register lets the next item
// be popped and read while a finished result waits on result_ready.
module sector_validity_tracker_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic                                 command,
    input  logic [svt_pkg::GRP_W-1:0]            pu_group,
    input  logic [svt_pkg::UNIT_W-1:0]           pu_unit,
    input  logic [svt_pkg::CHUNK_W-1:0]          chunk,
    input  logic [svt_pkg::SECTOR_W-1:0]         sector,
    input  logic                                 last_in_batch,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [svt_pkg::STATE_W-1:0]          prior_state,
    output logic [svt_pkg::COUNT_OUT_W-1:0]      valid_count,
    output logic [svt_pkg::COUNT_OUT_W-1:0]      invalid_count,
    output logic                                 changed,
    output logic                                 batch_done
);

    logic                    push;
    logic                    q_full;
    logic                    q_valid;
    logic                    pop;
    svt_pkg::svt_op_t        push_op;
    svt_pkg::svt_op_t        q_op;
    svt_pkg::svt_back_stat_t back_stat;

    // classify the input beat: range check and flat store addresses
    svt_front u_front (
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .command       (command),
        .pu_group      (pu_group),
        .pu_unit       (pu_unit),
        .chunk         (chunk),
        .sector        (sector),
        .last_in_batch (last_in_batch),
        .q_full        (q_full),
        .back_stat     (back_stat),
        .push          (push),
        .op            (push_op)
    );

    // decouples input beats from the read-modify-write in the back end
    svt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    // stores, update logic and result register
    svt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .pop           (pop),
        .back_stat     (back_stat),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .prior_state   (prior_state),
        .valid_count   (valid_count),
        .invalid_count (invalid_count),
        .changed       (changed),
        .batch_done    (batch_done)
    );

endmodule

// ===== hw/rtl/svt_front.sv =====
// Front end: takes input beats, range-checks and flattens the sector address.
module svt_front (
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic                            command,
    input  logic [svt_pkg::GRP_W-1:0]       pu_group,
    input  logic [svt_pkg::UNIT_W-1:0]      pu_unit,
    input  logic [svt_pkg::CHUNK_W-1:0]     chunk,
    input  logic [svt_pkg::SECTOR_W-1:0]    sector,
    input  logic                            last_in_batch,
    input  logic                            q_full,
    input  svt_pkg::svt_back_stat_t         back_stat,
    output logic                            push,
    output svt_pkg::svt_op_t                op
);

    logic        in_range;
    logic [63:0] ci_full;
    logic [63:0] si_full;

    assign item_ready = !q_full && !back_stat.clearing;
    assign push       = item_valid && item_ready;

    assign in_range = (32'(pu_group) < svt_pkg::NUM_PU_GROUPS) &&
                      (32'(pu_unit)  < svt_pkg::NUM_PU_UNITS)  &&
                      (32'(chunk)    < svt_pkg::NUM_CHUNKS)    &&
                      (32'(sector)   < svt_pkg::NUM_SECTORS);

    // chunk index = (group * units + unit) * chunks + chunk
    assign ci_full = (64'(pu_group) * 64'(svt_pkg::NUM_PU_UNITS) + 64'(pu_unit))
                     * 64'(svt_pkg::NUM_CHUNKS) + 64'(chunk);
    assign si_full = ci_full * 64'(svt_pkg::NUM_SECTORS) + 64'(sector);

    always_comb
    begin
        op.cmd      = command;
        op.in_range = in_range;
        op.ci       = in_range ? svt_pkg::CI_W'(ci_full) : '0;
        op.si       = in_range ? svt_pkg::SI_W'(si_full) : '0;
        op.last     = last_in_batch;
    end

endmodule

// ===== hw/rtl/svt_queue.sv =====
// Short FIFO of classified operations between front and back ends.
module svt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  svt_pkg::svt_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output svt_pkg::svt_op_t q_op
);

    svt_pkg::svt_op_t                   entry_reg [svt_pkg::QDEPTH];
    logic [svt_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [svt_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [svt_pkg::QCNT_W-1:0]         count_reg, count_next;

    assign full    = (count_reg == svt_pkg::QCNT_W'(svt_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == svt_pkg::QPTR_W'(svt_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + svt_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == svt_pkg::QPTR_W'(svt_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + svt_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + svt_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - svt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hw/rtl/svt_back.sv =====
// Back end: sector state and chunk count stores, clearing sweep, update, result register.
module svt_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  svt_pkg::svt_op_t                     q_op,
    output logic                                 pop,
    output svt_pkg::svt_back_stat_t              back_stat,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [svt_pkg::STATE_W-1:0]          prior_state,
    output logic [svt_pkg::COUNT_OUT_W-1:0]      valid_count,
    output logic [svt_pkg::COUNT_OUT_W-1:0]      invalid_count,
    output logic                                 changed,
    output logic                                 batch_done
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } svt_state_t;

    svt_state_t state_reg, state_next;
    logic [svt_pkg::SI_W-1:0] clr_cnt_reg, clr_cnt_next;

    // stores
    logic [svt_pkg::STATE_W-1:0] sector_mem  [svt_pkg::SECTOR_TOTAL];
    logic [svt_pkg::CNT_W-1:0]   valid_mem   [svt_pkg::CHUNK_TOTAL];
    logic [svt_pkg::CNT_W-1:0]   invalid_mem [svt_pkg::CHUNK_TOTAL];
    logic [svt_pkg::STATE_W-1:0] sec_rd_reg;
    logic [svt_pkg::CNT_W-1:0]   vc_rd_reg;
    logic [svt_pkg::CNT_W-1:0]   ic_rd_reg;

    svt_pkg::svt_op_t op_reg;

    logic                        sec_we;
    logic [svt_pkg::SI_W-1:0]    sec_wa;
    logic [svt_pkg::STATE_W-1:0] sec_wd;
    logic                        cnt_we;
    logic [svt_pkg::CI_W-1:0]    cnt_wa;
    logic [svt_pkg::CNT_W-1:0]   vc_wd;
    logic [svt_pkg::CNT_W-1:0]   ic_wd;

    logic [svt_pkg::STATE_W-1:0] st_new;
    logic [svt_pkg::CNT_W-1:0]   vc_new;
    logic [svt_pkg::CNT_W-1:0]   ic_new;
    logic                        chg;
    logic                        slot_free;
    logic                        load_out;

    logic                            out_valid_reg, out_valid_next;
    logic [svt_pkg::STATE_W-1:0]     prior_reg;
    logic [svt_pkg::COUNT_OUT_W-1:0] vc_out_reg;
    logic [svt_pkg::COUNT_OUT_W-1:0] ic_out_reg;
    logic                            chg_out_reg;
    logic                            batch_reg;

    assign back_stat.clearing = (state_reg == S_CLEAR);
    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign slot_free = !out_valid_reg || result_ready;
    assign load_out  = (state_reg == S_EXEC) && slot_free;

    // new sector state and counts from the fetched values
    always_comb
    begin
        st_new = sec_rd_reg;
        vc_new = vc_rd_reg;
        ic_new = ic_rd_reg;
        chg    = 1'b0;
        unique case (op_reg.cmd)
            svt_pkg::CMD_MARK_VALID:
            begin
                if (sec_rd_reg == svt_pkg::ST_UNUSED || sec_rd_reg == svt_pkg::ST_INVALID)
                begin
                    if (sec_rd_reg == svt_pkg::ST_INVALID && ic_rd_reg != '0)
                    begin
                        ic_new = ic_rd_reg - svt_pkg::CNT_W'(1);
                    end
                    vc_new = vc_rd_reg + svt_pkg::CNT_W'(1);
                    st_new = svt_pkg::ST_VALID;
                    chg    = 1'b1;
                end
            end
            svt_pkg::CMD_MARK_INVALID:
            begin
                if (sec_rd_reg == svt_pkg::ST_VALID)
                begin
                    if (vc_rd_reg != '0)
                    begin
                        vc_new = vc_rd_reg - svt_pkg::CNT_W'(1);
                    end
                    ic_new = ic_rd_reg + svt_pkg::CNT_W'(1);
                    st_new = svt_pkg::ST_INVALID;
                    chg    = 1'b1;
                end
            end
            default:
            begin
                chg = 1'b0;
            end
        endcase
    end

    // store write port: clearing sweep or write-back of a changed sector
    always_comb
    begin
        sec_we = 1'b0;
        sec_wa = op_reg.si;
        sec_wd = st_new;
        cnt_we = 1'b0;
        cnt_wa = op_reg.ci;
        vc_wd  = vc_new;
        ic_wd  = ic_new;
        if (state_reg == S_CLEAR)
        begin
            sec_we = 1'b1;
            sec_wa = clr_cnt_reg;
            sec_wd = svt_pkg::ST_UNUSED;
            cnt_we = (32'(clr_cnt_reg) < svt_pkg::CHUNK_TOTAL);
            cnt_wa = clr_cnt_reg[svt_pkg::CI_W-1:0];
            vc_wd  = '0;
            ic_wd  = '0;
        end
        else if (load_out && op_reg.in_range && chg)
        begin
            sec_we = 1'b1;
            cnt_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sec_we)
        begin
            sector_mem[sec_wa] <= sec_wd;
        end
        if (pop)
        begin
            sec_rd_reg <= sector_mem[q_op.si];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            valid_mem[cnt_wa]   <= vc_wd;
            invalid_mem[cnt_wa] <= ic_wd;
        end
        if (pop)
        begin
            vc_rd_reg <= valid_mem[q_op.ci];
            ic_rd_reg <= invalid_mem[q_op.ci];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + svt_pkg::SI_W'(1);
                if (clr_cnt_reg == svt_pkg::SI_W'(svt_pkg::SECTOR_TOTAL - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= q_op;
        end
        if (load_out)
        begin
            prior_reg   <= op_reg.in_range ? sec_rd_reg : svt_pkg::ST_UNUSED;
            vc_out_reg  <= op_reg.in_range ? svt_pkg::COUNT_OUT_W'(vc_new) : '0;
            ic_out_reg  <= op_reg.in_range ? svt_pkg::COUNT_OUT_W'(ic_new) : '0;
            chg_out_reg <= op_reg.in_range && chg;
            batch_reg   <= op_reg.last;
        end
    end

    assign result_valid  = out_valid_reg;
    assign prior_state   = prior_reg;
    assign valid_count   = vc_out_reg;
    assign invalid_count = ic_out_reg;
    assign changed       = chg_out_reg;
    assign batch_done    = batch_reg;

    // no operation leaves the queue during the clearing sweep
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pop)
        else $error("pop during clearing sweep");

    // outside the sweep, the stores are written only as a result is loaded
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (sec_we && state_reg != S_CLEAR) |-> load_out)
        else $error("store write without a result");

    // a reported prior state is never the reserved code
    a_prior_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && op_reg.in_range) |=> (prior_state != svt_pkg::ST_RESERVED))
        else $error("reserved sector state read");

    // a chunk never counts more sectors than it holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && op_reg.in_range) |->
        ((32'(vc_new) + 32'(ic_new)) <= svt_pkg::NUM_SECTORS))
        else $error("chunk count overflow");

endmodule
